>>> sv/ccd_pkg.sv
// ----------------------------------------------------------------------------
// ccd_pkg: shared types and constants for the countdown clock display
// Operation codes, field widths, reciprocal constants and BCD helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package ccd_pkg;

  localparam int MS_W    = 27;  // remaining / budget time in ms
  localparam int STAMP_W = 32;  // timestamp width
  localparam int SECS_W  = 17;  // whole seconds, below one day
  localparam int MINS_W  = 11;  // whole minutes, below one day
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;
  localparam int DIG_W   = 4;

  localparam logic [MS_W-1:0] MAX_LOAD_MS = 27'd86399999;

  // floor(x / 125) = (x * RECIP_125) >> 31, exact for x < 2^24
  localparam logic [24:0] RECIP_125 = 25'd17179870;
  localparam int          SHIFT_125 = 31;
  // floor(x / 15) = (x * RECIP_15) >> 19, exact for x < 2^15
  localparam logic [15:0] RECIP_15  = 16'd34953;
  localparam int          SHIFT_15  = 19;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_START  = 2'd1,
    OP_UPDATE = 2'd2,
    OP_PAUSE  = 2'd3
  } op_t;

  // Time value on its way into the display split
  typedef struct packed {
    logic [MS_W-1:0] ms;
    logic            refresh;
    logic            stopped;
  } ccd_ms_t;

  // Split time leaving the display split
  typedef struct packed {
    logic [HOUR_W-1:0] hours;
    logic [MIN_W-1:0]  minutes;
    logic [SEC_W-1:0]  seconds;
    logic              refresh;
    logic              stopped;
  } ccd_hms_t;

  // Tens digit of a value below 64: (v * 205) >> 11
  function automatic logic [DIG_W-1:0] bcd_tens(input logic [5:0] v);
    logic [13:0] prod;
    prod = 14'(v) * 14'd205;
    return {1'b0, prod[13:11]};
  endfunction

  function automatic logic [DIG_W-1:0] bcd_units(input logic [5:0] v);
    logic [5:0] rem;
    rem = v - 6'(bcd_tens(v)) * 6'd10;
    return rem[3:0];
  endfunction

endpackage

`default_nettype wire

>>> sv/ccd_in_if.sv
// ----------------------------------------------------------------------------
// ccd_in_if: command channel of the countdown clock display
// Valid/ready channel carrying one operation and one millisecond value.
// ----------------------------------------------------------------------------
`default_nettype none

interface ccd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] value_ms;

  modport source (output valid, output operation, output value_ms, input ready);
  modport sink   (input valid, input operation, input value_ms, output ready);
endinterface

`default_nettype wire

>>> sv/ccd_out_if.sv
// ----------------------------------------------------------------------------
// ccd_out_if: display channel of the countdown clock display
// Valid/ready channel carrying four BCD digits and the display flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface ccd_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] digit_three;
  logic [3:0] digit_two;
  logic [3:0] digit_one;
  logic [3:0] digit_zero;
  logic       colon_on;
  logic       hours_mode;
  logic       stopped;

  modport source (output valid, output digit_three, output digit_two,
                  output digit_one, output digit_zero, output colon_on,
                  output hours_mode, output stopped, input ready);
  modport sink   (input valid, input digit_three, input digit_two,
                  input digit_one, input digit_zero, input colon_on,
                  input hours_mode, input stopped, output ready);
endinterface

`default_nettype wire

>>> sv/countdown_clock_display.sv
// ----------------------------------------------------------------------------
// countdown_clock_display: millisecond countdown timer with clock display
// Timer state update, time split pipeline and BCD display register.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one command per transfer. operation = load / start / update /
//            pause, value_ms = duration (load) or current timestamp.
//   out_ch : exactly one display word per command, in command order:
//            four BCD digits (HH:MM when hours are nonzero, else MM:SS),
//            colon_on on even seconds, hours_mode and the stopped flag.
//   Timer state (remaining, budget, start stamp, stopped) is updated at the
//   input transfer itself, so commands may follow every cycle unless stalled.
//   Path: the result passes the state stage, three divide stages, the split
//   remainder stage and the display register, in that order. Throughput:
//   one command per cycle while out_ch.ready is high, through the six-register
//   pipeline.
//   Stall: when out_ch.ready is low the result holds; each stage keeps
//   taking transfers until it is full, then in_ch.ready drops.
//   Reset (rst_n low, synchronous): all timer and shown values are zero,
//   the pipeline is empty and no result is pending.
// ----------------------------------------------------------------------------
`default_nettype none

module countdown_clock_display (
  input  wire logic clk,
  input  wire logic rst_n,
  ccd_in_if.sink    in_ch,
  ccd_out_if.source out_ch
);
  import ccd_pkg::*;

  // ---------------- timer state ----------------
  logic [MS_W-1:0]    remaining_r, remaining_nxt;
  logic [MS_W-1:0]    budget_r, budget_nxt;
  logic [STAMP_W-1:0] stamp_r, stamp_nxt;
  logic               stopped_r, stopped_nxt;
  logic               refresh;

  op_t                op;
  logic               in_xfer;
  logic [STAMP_W-1:0] elapsed;
  logic [MS_W-1:0]    remain_upd;
  logic [MS_W-1:0]    load_ms;

  // ---------------- pipeline ----------------
  logic      s1_valid_r;
  ccd_ms_t   s1_data_r;
  logic      load_s1;
  logic      split_ready;
  logic      split_valid;
  ccd_hms_t  split_data;

  // ---------------- display ----------------
  logic              out_valid_r;
  logic              load_out;
  logic [HOUR_W-1:0] shown_hours_r, shown_hours_nxt;
  logic [MIN_W-1:0]  shown_minutes_r, shown_minutes_nxt;
  logic [SEC_W-1:0]  shown_seconds_r, shown_seconds_nxt;
  logic              hours_mode;
  logic [5:0]        left_val, right_val;
  logic [DIG_W-1:0]  digit_three_r, digit_two_r, digit_one_r, digit_zero_r;
  logic              colon_on_r, hours_mode_r, stopped_out_r;

  assign op       = op_t'(in_ch.operation);
  assign load_s1  = !s1_valid_r || split_ready;
  assign in_ch.ready = load_s1;
  assign in_xfer  = in_ch.valid && load_s1;

  // modular elapsed time, remaining clamps at zero
  assign elapsed    = in_ch.value_ms - stamp_r;
  assign remain_upd = (STAMP_W'(budget_r) > elapsed) ? (budget_r - elapsed[MS_W-1:0])
                                                     : '0;
  assign load_ms    = (in_ch.value_ms > STAMP_W'(MAX_LOAD_MS)) ? MAX_LOAD_MS
                                                               : in_ch.value_ms[MS_W-1:0];

  always_comb begin
    remaining_nxt = remaining_r;
    budget_nxt    = budget_r;
    stamp_nxt     = stamp_r;
    stopped_nxt   = stopped_r;
    refresh       = 1'b0;
    case (op)
      OP_LOAD: begin
        remaining_nxt = load_ms;
        budget_nxt    = load_ms;
        stopped_nxt   = 1'b0;
      end
      OP_START: begin
        stamp_nxt = in_ch.value_ms;
      end
      OP_UPDATE: begin
        if (remaining_r == '0) begin
          stopped_nxt = 1'b1;   // already at zero: display untouched
        end else begin
          remaining_nxt = remain_upd;
          refresh       = 1'b1;
        end
      end
      OP_PAUSE: begin
        budget_nxt = remaining_r;
      end
      default: begin
        remaining_nxt = remaining_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remaining_r <= '0;
      budget_r    <= '0;
      stamp_r     <= '0;
      stopped_r   <= 1'b0;
      s1_valid_r  <= 1'b0;
    end else begin
      if (in_xfer) begin
        remaining_r <= remaining_nxt;
        budget_r    <= budget_nxt;
        stamp_r     <= stamp_nxt;
        stopped_r   <= stopped_nxt;
      end
      if (load_s1) s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_data_r.ms      <= remaining_nxt;
      s1_data_r.refresh <= refresh;
      s1_data_r.stopped <= stopped_nxt;
    end
  end

  ccd_split u_split (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid_r),
    .up_ready (split_ready),
    .up_data  (s1_data_r),
    .dn_valid (split_valid),
    .dn_ready (load_out),
    .dn_data  (split_data)
  );

  // ---------------- display register ----------------
  // Shown values change only with an update that recomputed the time.
  assign load_out = !out_valid_r || out_ch.ready;

  always_comb begin
    shown_hours_nxt   = shown_hours_r;
    shown_minutes_nxt = shown_minutes_r;
    shown_seconds_nxt = shown_seconds_r;
    if (split_data.refresh) begin
      shown_hours_nxt   = split_data.hours;
      shown_minutes_nxt = split_data.minutes;
      shown_seconds_nxt = split_data.seconds;
    end
  end

  assign hours_mode = (shown_hours_nxt != '0);
  assign left_val   = hours_mode ? 6'(shown_hours_nxt) : shown_minutes_nxt;
  assign right_val  = hours_mode ? shown_minutes_nxt : shown_seconds_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r     <= 1'b0;
      shown_hours_r   <= '0;
      shown_minutes_r <= '0;
      shown_seconds_r <= '0;
    end else if (load_out) begin
      out_valid_r <= split_valid;
      if (split_valid) begin
        shown_hours_r   <= shown_hours_nxt;
        shown_minutes_r <= shown_minutes_nxt;
        shown_seconds_r <= shown_seconds_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out && split_valid) begin
      digit_three_r <= bcd_tens(left_val);
      digit_two_r   <= bcd_units(left_val);
      digit_one_r   <= bcd_tens(right_val);
      digit_zero_r  <= bcd_units(right_val);
      colon_on_r    <= !shown_seconds_nxt[0];
      hours_mode_r  <= hours_mode;
      stopped_out_r <= split_data.stopped;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.digit_three = digit_three_r;
  assign out_ch.digit_two   = digit_two_r;
  assign out_ch.digit_one   = digit_one_r;
  assign out_ch.digit_zero  = digit_zero_r;
  assign out_ch.colon_on    = colon_on_r;
  assign out_ch.hours_mode  = hours_mode_r;
  assign out_ch.stopped     = stopped_out_r;

  // ---------------- assertions ----------------
  // remaining never outgrows the budget, nor the budget the load limit
  a_remain_le_budget: assert property (@(posedge clk) disable iff (!rst_n)
    (remaining_r <= budget_r) && (budget_r <= MAX_LOAD_MS))
    else $error("remaining time above budget or load limit");

  // the stopped flag only rises on an accepted update
  a_stop_on_update: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(stopped_r) |-> $past(in_xfer && (op == OP_UPDATE)))
    else $error("stopped flag set without an update");

  // reciprocal split keeps every shown field in clock range
  a_shown_range: assert property (@(posedge clk) disable iff (!rst_n)
    (shown_hours_r < 5'd24) && (shown_minutes_r < 6'd60) && (shown_seconds_r < 6'd60))
    else $error("shown time field out of range");

endmodule

`default_nettype wire

>>> sv/ccd_split.sv
// ----------------------------------------------------------------------------
// ccd_split: millisecond to hours / minutes / seconds pipeline
// Four stages: three constant-reciprocal multiplies, two remainder subtracts.
// ----------------------------------------------------------------------------
`default_nettype none

module ccd_split (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            up_valid,
  output logic                 up_ready,
  input  wire ccd_pkg::ccd_ms_t  up_data,
  output logic                 dn_valid,
  input  wire logic            dn_ready,
  output ccd_pkg::ccd_hms_t    dn_data
);
  import ccd_pkg::*;

  // stage valids
  logic va_r, vb_r, vc_r, vd_r;
  logic load_a, load_b, load_c, load_d;

  // stage A: whole seconds
  logic [SECS_W-1:0] a_secs_r;
  logic              a_refresh_r, a_stopped_r;
  // stage B: whole minutes, seconds carried
  logic [SECS_W-1:0] b_secs_r;
  logic [MINS_W-1:0] b_mins_r;
  logic              b_refresh_r, b_stopped_r;
  // stage C: hours and seconds field
  logic [MINS_W-1:0] c_mins_r;
  logic [HOUR_W-1:0] c_hours_r;
  logic [SEC_W-1:0]  c_sec_r;
  logic              c_refresh_r, c_stopped_r;
  // stage D: result
  ccd_hms_t          d_r;

  logic [48:0]       prod_a;
  logic [30:0]       prod_b;
  logic [24:0]       prod_c;
  logic [SECS_W-1:0] sec_full;
  logic [MINS_W-1:0] min_full;

  assign load_d   = !vd_r || dn_ready;
  assign load_c   = !vc_r || load_d;
  assign load_b   = !vb_r || load_c;
  assign load_a   = !va_r || load_b;
  assign up_ready = load_a;
  assign dn_valid = vd_r;
  assign dn_data  = d_r;

  // ms / 1000 = (ms >> 3) / 125
  assign prod_a = 49'(up_data.ms[MS_W-1:3]) * 49'(RECIP_125);
  // secs / 60 = (secs >> 2) / 15
  assign prod_b = 31'(a_secs_r[SECS_W-1:2]) * 31'(RECIP_15);
  // mins / 60 = (mins >> 2) / 15
  assign prod_c = 25'(b_mins_r[MINS_W-1:2]) * 25'(RECIP_15);

  assign sec_full = b_secs_r - SECS_W'(b_mins_r) * SECS_W'(60);
  assign min_full = c_mins_r - MINS_W'(c_hours_r) * MINS_W'(60);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      if (load_a) va_r <= up_valid;
      if (load_b) vb_r <= va_r;
      if (load_c) vc_r <= vb_r;
      if (load_d) vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load_a) begin
      a_secs_r    <= prod_a[SHIFT_125+SECS_W-1:SHIFT_125];
      a_refresh_r <= up_data.refresh;
      a_stopped_r <= up_data.stopped;
    end
    if (load_b) begin
      b_secs_r    <= a_secs_r;
      b_mins_r    <= prod_b[SHIFT_15+MINS_W-1:SHIFT_15];
      b_refresh_r <= a_refresh_r;
      b_stopped_r <= a_stopped_r;
    end
    if (load_c) begin
      c_mins_r    <= b_mins_r;
      c_hours_r   <= prod_c[SHIFT_15+HOUR_W-1:SHIFT_15];
      c_sec_r     <= sec_full[SEC_W-1:0];
      c_refresh_r <= b_refresh_r;
      c_stopped_r <= b_stopped_r;
    end
    if (load_d) begin
      d_r.hours   <= c_hours_r;
      d_r.minutes <= min_full[MIN_W-1:0];
      d_r.seconds <= c_sec_r;
      d_r.refresh <= c_refresh_r;
      d_r.stopped <= c_stopped_r;
    end
  end

endmodule

`default_nettype wire

>>> bench/tb_countdown_clock_display.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_countdown_clock_display: self-checking bench for the countdown display
// Drives load / start / update / pause commands over the valid/ready command
// channel, predicts every display word from its own timer model and checks
// each word on the display channel in order. Both channels see random gaps.
// ----------------------------------------------------------------------------

module tb_countdown_clock_display;
  import ccd_pkg::*;

  // One display word as seen on the result channel
  typedef struct packed {
    logic [DIG_W-1:0] digit_three;
    logic [DIG_W-1:0] digit_two;
    logic [DIG_W-1:0] digit_one;
    logic [DIG_W-1:0] digit_zero;
    logic             colon_on;
    logic             hours_mode;
    logic             stopped;
  } display_word_t;

  logic clk;
  logic rst_n;

  ccd_in_if  in_ch ();
  ccd_out_if out_ch ();

  countdown_clock_display i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // --------------------------------------------------------------------------
  // Timer model: our own copy of remaining / budget / stamp / stopped and the
  // hours, minutes, seconds last pushed to the display.
  // --------------------------------------------------------------------------
  logic [MS_W-1:0]    rem_ms;
  logic [MS_W-1:0]    budget;
  logic [STAMP_W-1:0] stamp;
  logic               halted;
  logic [HOUR_W-1:0]  shown_hrs;
  logic [MIN_W-1:0]   shown_min;
  logic [SEC_W-1:0]   shown_sec;

  display_word_t pending_displays[$];

  // bookkeeping
  int  n_fail;
  int  n_cmds;
  int  n_updates;
  int  n_stops;
  int  n_checked;
  int  n_random;
  bit  no_idle;     // when set, neither side inserts gaps

  // Apply one accepted command to the timer model
  task automatic advance_timer(input op_t op, input logic [STAMP_W-1:0] val);
    int unsigned elapsed;
    int unsigned whole;
    case (op)
      OP_LOAD: begin
        // durations beyond one day minus a millisecond saturate
        if (val > 32'(MAX_LOAD_MS)) rem_ms = MAX_LOAD_MS;
        else rem_ms = val[MS_W-1:0];
        budget = rem_ms;
        halted = 1'b0;
      end
      OP_START: stamp = val;
      OP_UPDATE: begin
        n_updates++;
        if (rem_ms == '0) begin
          // already at zero: only the stopped flag moves, display stays
          halted = 1'b1;
          n_stops++;
        end else begin
          elapsed = val - stamp;  // modular 32-bit difference
          if (32'(budget) > elapsed) rem_ms = MS_W'(32'(budget) - elapsed);
          else rem_ms = '0;       // clamp, never negative
          whole     = 32'(rem_ms) / 1000;
          shown_hrs = HOUR_W'((whole % 86400) / 3600);
          shown_min = MIN_W'((whole / 60) % 60);
          shown_sec = SEC_W'(whole % 60);
        end
      end
      default: budget = rem_ms;  // pause
    endcase
  endtask

  // Display word implied by the shown values
  function automatic display_word_t display_now();
    int unsigned   left;
    int unsigned   right;
    display_word_t w;
    if (shown_hrs != '0) begin
      left  = shown_hrs;
      right = shown_min;
    end else begin
      left  = shown_min;
      right = shown_sec;
    end
    w.digit_three = DIG_W'(left / 10);
    w.digit_two   = DIG_W'(left % 10);
    w.digit_one   = DIG_W'(right / 10);
    w.digit_zero  = DIG_W'(right % 10);
    w.colon_on    = (shown_sec % 2) == 0;
    w.hours_mode  = shown_hrs != '0;
    w.stopped     = halted;
    return w;
  endfunction

  // Gap length: mostly none or short, now and then long
  function automatic int unsigned idle_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // --------------------------------------------------------------------------
  // Clock, reset, watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Worst case is far below this: ~1000 commands, each at most the longest send
  // gap plus the longest display stall plus pipeline depth.
  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Display channel: random stalls on ready
  // --------------------------------------------------------------------------
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0 && !no_idle) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        stall_left = ($urandom_range(0, 3) == 0) ? idle_gap() : 0;
      end
    end
  end

  // Check every display transfer against the oldest prediction
  always @(posedge clk) begin
    display_word_t exp_w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_displays.size() == 0) begin
        $error("display transfer with no command outstanding");
        n_fail++;
      end else begin
        exp_w = pending_displays.pop_front();
        n_checked++;
        if (out_ch.digit_three !== exp_w.digit_three) begin
          $error("digit_three expected %0d got %0d", exp_w.digit_three, out_ch.digit_three);
          n_fail++;
        end
        if (out_ch.digit_two !== exp_w.digit_two) begin
          $error("digit_two expected %0d got %0d", exp_w.digit_two, out_ch.digit_two);
          n_fail++;
        end
        if (out_ch.digit_one !== exp_w.digit_one) begin
          $error("digit_one expected %0d got %0d", exp_w.digit_one, out_ch.digit_one);
          n_fail++;
        end
        if (out_ch.digit_zero !== exp_w.digit_zero) begin
          $error("digit_zero expected %0d got %0d", exp_w.digit_zero, out_ch.digit_zero);
          n_fail++;
        end
        if (out_ch.colon_on !== exp_w.colon_on) begin
          $error("colon_on expected %0d got %0d", exp_w.colon_on, out_ch.colon_on);
          n_fail++;
        end
        if (out_ch.hours_mode !== exp_w.hours_mode) begin
          $error("hours_mode expected %0d got %0d", exp_w.hours_mode, out_ch.hours_mode);
          n_fail++;
        end
        if (out_ch.stopped !== exp_w.stopped) begin
          $error("stopped expected %0d got %0d", exp_w.stopped, out_ch.stopped);
          n_fail++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Command channel
  // --------------------------------------------------------------------------
  // valid is dropped only at the start of a send that has a gap or while
  // draining, so it is never lowered and raised within one time step.
  task automatic send_cmd(input op_t op, input logic [STAMP_W-1:0] val);
    int unsigned gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.value_ms  <= val;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    // transfer happened at this edge
    advance_timer(op, val);
    pending_displays.push_back(display_now());
    n_cmds++;
  endtask

  // Hold off the sender until every display word has come back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_displays.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Fresh out of reset: zero display, update at zero sets stopped
  task automatic test_after_reset();
    send_cmd(OP_PAUSE, 32'hFFFF_FFFF);
    send_cmd(OP_UPDATE, 32'd0);
    send_cmd(OP_LOAD, 32'd0);        // load clears stopped, display stays
    send_cmd(OP_UPDATE, 32'd12345);  // zero again -> stopped
  endtask

  // Largest load, oversized loads, hour / minute boundaries
  task automatic test_load_extremes();
    send_cmd(OP_LOAD, 32'hFFFF_FFFF);  // saturates
    send_cmd(OP_START, 32'd0);
    send_cmd(OP_UPDATE, 32'd0);        // 23:59, odd seconds -> dash
    send_cmd(OP_LOAD, 32'd86400000);   // one above the cap
    send_cmd(OP_START, 32'h8000_0000);
    send_cmd(OP_UPDATE, 32'h8000_0000);
    send_cmd(OP_LOAD, 32'd3599999);    // 59:59 in minutes mode
    send_cmd(OP_UPDATE, 32'h8000_0000);
    send_cmd(OP_LOAD, 32'd3600000);    // 01:00 in hours mode
    send_cmd(OP_UPDATE, 32'h8000_0000);
    send_cmd(OP_LOAD, 32'd1000);
    send_cmd(OP_UPDATE, 32'h8000_0001); // 999 ms left shows 00:00
  endtask

  // Elapsed beyond budget clamps; next update stops; pause freezes budget
  task automatic test_clamp_and_stop();
    send_cmd(OP_LOAD, 32'd5000);
    send_cmd(OP_START, 32'd100);
    send_cmd(OP_UPDATE, 32'd2100);     // 3 s left
    send_cmd(OP_PAUSE, 32'd0);
    send_cmd(OP_START, 32'd900000);
    send_cmd(OP_UPDATE, 32'd901500);   // budget now 3000, 1.5 s left
    send_cmd(OP_UPDATE, 32'd99999999); // far past -> clamp to zero
    send_cmd(OP_UPDATE, 32'd99999999); // at zero -> stopped
  endtask

  // Start stamp just below the 32-bit wrap, update just after it
  task automatic test_stamp_wrap();
    send_cmd(OP_LOAD, 32'd65000);
    send_cmd(OP_START, 32'hFFFF_FF00);
    send_cmd(OP_UPDATE, 32'h0000_0100);  // 512 ms elapsed across the wrap
  endtask

  // Well-formed countdown sessions with random content, plus some noise
  task automatic test_random_sessions(input int target);
    int unsigned dur;
    int unsigned t;
    int unsigned n_upd;
    int unsigned r;
    int          last;
    last = n_random + target;
    while (n_random < last) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        // noise: any operation with any value
        send_cmd(op_t'($urandom_range(0, 3)), $urandom);
        n_random++;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) dur = $urandom_range(0, 200000);
        else if (r < 90) dur = $urandom_range(0, 86399999);
        else dur = $urandom;                        // mostly oversized
        // start stamps now and then just below the wrap
        t = ($urandom_range(0, 4) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 200000)
                                         : $urandom;
        send_cmd(OP_LOAD, dur);
        send_cmd(OP_START, t);
        n_random += 2;
        if (dur > 86399999) dur = 86399999;
        n_upd = $urandom_range(3, 12);
        repeat (n_upd) begin
          r = $urandom_range(0, 99);
          if (r < 10) begin
            send_cmd(OP_PAUSE, $urandom);
            t += $urandom_range(0, 100000);
            send_cmd(OP_START, t);
            n_random += 2;
          end else begin
            if (r < 18) t += dur + $urandom_range(0, 1000);  // overshoot
            else t += $urandom_range(0, dur / 4 + 50);
            send_cmd(OP_UPDATE, t);
            n_random++;
          end
        end
        if ($urandom_range(0, 19) == 0) wait_drained();
      end
    end
  endtask

  // Sender pauses until the results in flight drain, then resumes
  task automatic test_drain_pause();
    send_cmd(OP_LOAD, 32'd7200000);
    send_cmd(OP_START, 32'd10);
    send_cmd(OP_UPDATE, 32'd1010);
    wait_drained();
    send_cmd(OP_UPDATE, 32'd3601010);
    send_cmd(OP_PAUSE, 32'd0);
    wait_drained();
  endtask

  initial begin
    n_fail    = 0;
    n_cmds    = 0;
    n_updates = 0;
    n_stops   = 0;
    n_checked = 0;
    n_random  = 0;
    no_idle   = 1'b0;
    rem_ms    = '0;
    budget    = '0;
    stamp     = '0;
    halted    = 1'b0;
    shown_hrs = '0;
    shown_min = '0;
    shown_sec = '0;

    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= OP_LOAD;
    in_ch.value_ms  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_after_reset();
    test_load_extremes();
    test_clamp_and_stop();
    test_stamp_wrap();
    test_drain_pause();

    // a stretch with no gaps on either side, then the idling mix
    no_idle = 1'b1;
    test_random_sessions(150);
    no_idle = 1'b0;
    test_random_sessions(750);

    // drain, then allow for the pipeline depth before the verdict
    in_ch.valid <= 1'b0;
    while (pending_displays.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Covered %0d commands (%0d updates, %0d hit the stopped state)",
             n_cmds, n_updates, n_stops);
    $display("Checked %0d display words, %0d mismatches", n_checked, n_fail);
    if (n_fail == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
